FILE: rtl/jeop_pkg.sv
package jeop_pkg;

   localparam int SEG_ADDR_W = 16;
   localparam int WIN_BYTES  = 14;
   localparam int WIN_IDX_W  = 4;

   localparam logic [7:0] MK_FILL = 8'hff;
   localparam logic [7:0] MK_SOI  = 8'hd8;
   localparam logic [7:0] MK_SOS  = 8'hda;
   localparam logic [7:0] MK_EOI  = 8'hd9;
   localparam logic [7:0] MK_TEM  = 8'h01;
   localparam logic [7:0] MK_RST0 = 8'hd0;
   localparam logic [7:0] MK_RST7 = 8'hd7;
   localparam logic [7:0] MK_APP1 = 8'he1;

   localparam logic [15:0] TAG_ORIENT  = 16'h0112;
   localparam logic [15:0] TYPE_SHORT  = 16'd3;
   localparam logic [15:0] TIFF_MAGIC  = 16'd42;
   localparam logic [15:0] ENTRY_BYTES = 16'd12;
   localparam logic [15:0] MIN_EXIF    = 16'd14;

   localparam logic [3:0] ORIENT_DEFAULT = 4'd1;

   typedef struct packed {
      logic       done;
      logic       decided;
      logic [3:0] value;
   } walk_result_type;

   function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic lit);
      return lit ? {b1, b0} : {b0, b1};
   endfunction

   function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic lit);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = get16(b0, b1, lit);
      hi = get16(b2, b3, lit);
      return lit ? {hi, lo} : {lo, hi};
   endfunction

endpackage

FILE: rtl/jeop_store.sv
module jeop_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [jeop_pkg::SEG_ADDR_W-1:0]   wr_addr,
   input  logic [7:0]                        wr_data,
   input  logic                              rd_en,
   input  logic [jeop_pkg::SEG_ADDR_W-1:0]   rd_addr,
   output logic [7:0]                        rd_data
);

   logic [7:0] mem [2**jeop_pkg::SEG_ADDR_W];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/jeop_walker.sv
module jeop_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [15:0]                       seg_len,
   output logic                              rd_en,
   output logic [jeop_pkg::SEG_ADDR_W-1:0]   rd_addr,
   input  logic [7:0]                        rd_data,
   output jeop_pkg::walk_result_type         result
);

   localparam logic [3:0] W_IDLE      = 4'd0;
   localparam logic [3:0] W_HDR_LOAD  = 4'd1;
   localparam logic [3:0] W_HDR_CHECK = 4'd2;
   localparam logic [3:0] W_CNT_LOAD  = 4'd3;
   localparam logic [3:0] W_CNT_CHECK = 4'd4;
   localparam logic [3:0] W_ENT_TEST  = 4'd5;
   localparam logic [3:0] W_ENT_LOAD  = 4'd6;
   localparam logic [3:0] W_ENT_CHECK = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [15:0] n_ff, n_in;
   logic [16:0] off_ff, off_in;
   logic [15:0] entries_ff, entries_in;
   logic        little_ff, little_in;
   logic [3:0]  value_ff, value_in;
   logic [15:0] base_ff, base_in;
   logic [jeop_pkg::WIN_IDX_W-1:0] cnt_ff, cnt_in;
   logic [jeop_pkg::WIN_IDX_W-1:0] iss_ff, iss_in;
   logic        pend_ff, pend_in;
   logic [jeop_pkg::WIN_IDX_W-1:0] pidx_ff, pidx_in;
   logic [7:0]  win_ff [jeop_pkg::WIN_BYTES];
   jeop_pkg::walk_result_type res_ff, res_in;

   logic        loading;
   logic        load_done;
   logic        lit;
   logic        hdr_ok;
   logic [31:0] hdr_off;
   logic [15:0] ent_tag, ent_type, ent_val;
   logic [31:0] ent_cnt;
   logic [16:0] n_wide;

   assign loading   = (state_ff == W_HDR_LOAD) || (state_ff == W_CNT_LOAD) ||
                      (state_ff == W_ENT_LOAD);
   assign load_done = (iss_ff == cnt_ff) && !pend_ff;
   assign rd_en     = loading && (iss_ff != cnt_ff);
   assign rd_addr   = base_ff + {{(16-jeop_pkg::WIN_IDX_W){1'b0}}, iss_ff};
   assign result    = res_ff;
   assign n_wide    = {1'b0, n_ff};

   always_comb begin
      lit = (win_ff[6] == 8'h49);
      hdr_ok = (win_ff[0] == 8'h45) && (win_ff[1] == 8'h78) && (win_ff[2] == 8'h69) &&
               (win_ff[3] == 8'h66) && (win_ff[4] == 8'h00) && (win_ff[5] == 8'h00) &&
               (((win_ff[6] == 8'h49) && (win_ff[7] == 8'h49)) ||
                ((win_ff[6] == 8'h4d) && (win_ff[7] == 8'h4d))) &&
               (jeop_pkg::get16(win_ff[8], win_ff[9], lit) == jeop_pkg::TIFF_MAGIC);
      hdr_off  = jeop_pkg::get32(win_ff[10], win_ff[11], win_ff[12], win_ff[13], lit);
      ent_tag  = jeop_pkg::get16(win_ff[0], win_ff[1], little_ff);
      ent_type = jeop_pkg::get16(win_ff[2], win_ff[3], little_ff);
      ent_cnt  = jeop_pkg::get32(win_ff[4], win_ff[5], win_ff[6], win_ff[7], little_ff);
      ent_val  = jeop_pkg::get16(win_ff[8], win_ff[9], little_ff);
   end

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      off_in     = off_ff;
      entries_in = entries_ff;
      little_in  = little_ff;
      value_in   = value_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      iss_in     = iss_ff;
      pend_in    = 1'b0;
      pidx_in    = iss_ff;
      res_in     = '0;
      if (rd_en) begin
         iss_in  = iss_ff + 1'b1;
         pend_in = 1'b1;
      end
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               if (seg_len < jeop_pkg::MIN_EXIF) begin
                  res_in.done = 1'b1;
               end else begin
                  n_in     = seg_len - 16'd6;
                  base_in  = '0;
                  cnt_in   = jeop_pkg::WIN_IDX_W'(jeop_pkg::WIN_BYTES);
                  iss_in   = '0;
                  state_in = W_HDR_LOAD;
               end
            end
         end
         W_HDR_LOAD: begin
            if (load_done) begin
               state_in = W_HDR_CHECK;
            end
         end
         W_HDR_CHECK: begin
            if (!hdr_ok || (hdr_off > {16'd0, n_ff - 16'd2})) begin
               res_in.done = 1'b1;
               state_in    = W_IDLE;
            end else begin
               little_in = lit;
               off_in    = hdr_off[16:0];
               base_in   = hdr_off[15:0] + 16'd6;
               cnt_in    = jeop_pkg::WIN_IDX_W'(2);
               iss_in    = '0;
               state_in  = W_CNT_LOAD;
            end
         end
         W_CNT_LOAD: begin
            if (load_done) begin
               state_in = W_CNT_CHECK;
            end
         end
         W_CNT_CHECK: begin
            entries_in = jeop_pkg::get16(win_ff[0], win_ff[1], little_ff);
            off_in     = off_ff + 17'd2;
            value_in   = jeop_pkg::ORIENT_DEFAULT;
            state_in   = W_ENT_TEST;
         end
         W_ENT_TEST: begin
            if ((entries_ff != 16'd0) && (off_ff <= n_wide) &&
                ((n_wide - off_ff) >= {1'b0, jeop_pkg::ENTRY_BYTES})) begin
               base_in  = off_ff[15:0] + 16'd6;
               cnt_in   = jeop_pkg::WIN_IDX_W'(10);
               iss_in   = '0;
               state_in = W_ENT_LOAD;
            end else begin
               res_in.done    = 1'b1;
               res_in.decided = 1'b1;
               res_in.value   = value_ff;
               state_in       = W_IDLE;
            end
         end
         W_ENT_LOAD: begin
            if (load_done) begin
               state_in = W_ENT_CHECK;
            end
         end
         W_ENT_CHECK: begin
            if ((ent_tag == jeop_pkg::TAG_ORIENT) && (ent_type == jeop_pkg::TYPE_SHORT) &&
                (ent_cnt == 32'd1)) begin
               res_in.done    = 1'b1;
               res_in.decided = 1'b1;
               res_in.value   = ((ent_val >= 16'd1) && (ent_val <= 16'd8)) ?
                                ent_val[3:0] : jeop_pkg::ORIENT_DEFAULT;
               state_in       = W_IDLE;
            end else begin
               entries_in = entries_ff - 16'd1;
               off_in     = off_ff + {1'b0, jeop_pkg::ENTRY_BYTES};
               state_in   = W_ENT_TEST;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         pend_ff  <= 1'b0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         res_ff   <= res_in;
      end
      n_ff       <= n_in;
      off_ff     <= off_in;
      entries_ff <= entries_in;
      little_ff  <= little_in;
      value_ff   <= value_in;
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      iss_ff     <= iss_in;
      pidx_ff    <= pidx_in;
      if (pend_ff) begin
         win_ff[pidx_ff] <= rd_data;
      end
   end

endmodule

FILE: rtl/jpeg_exif_orientation_parser.sv
// JPEG Exif orientation parser: takes a JPEG file one byte per item and returns
// one orientation (1..8, 1 when absent or invalid) per file, as soon as it is
// decided or with the file's last byte. Marker walking and segment skipping take
// one cycle per byte; an APP1 segment is written to a 64 KiB byte store as it
// arrives. When an APP1 segment completes, input stalls while a sequencer reads
// the store back through its single read port, one byte per cycle: first the
// TIFF header and IFD count (only the header when it is rejected, nothing for a
// segment too short to hold one), then each IFD entry examined.
// A new byte is also held off while a result waits to be taken.
module jpeg_exif_orientation_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_file_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_orientation_value
);

   localparam logic [3:0] PH_SOI0    = 4'd0;
   localparam logic [3:0] PH_SOI1    = 4'd1;
   localparam logic [3:0] PH_MARK_FF = 4'd2;
   localparam logic [3:0] PH_MARKER  = 4'd3;
   localparam logic [3:0] PH_LEN_HI  = 4'd4;
   localparam logic [3:0] PH_LEN_LO  = 4'd5;
   localparam logic [3:0] PH_SKIP    = 4'd6;
   localparam logic [3:0] PH_STORE   = 4'd7;
   localparam logic [3:0] PH_DONE    = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] wr_idx_ff, wr_idx_in;
   logic [3:0]  found_ff, found_in;
   logic        sent_ff, sent_in;
   logic        walking_ff, walking_in;
   logic        last_pend_ff, last_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_val_ff, rsp_val_in;

   logic        accept;
   logic        fin;
   logic        last_v;
   logic        start;
   logic        mem_we;
   logic [15:0] total;
   logic [15:0] seg_len;
   logic        rd_en;
   logic [jeop_pkg::SEG_ADDR_W-1:0] rd_addr;
   logic [7:0]  rd_data;
   jeop_pkg::walk_result_type walk;

   assign req_ready             = !walking_ff && !rsp_valid_ff;
   assign accept                = req_valid && req_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_orientation_value = rsp_val_ff;
   assign total                 = {len_hi_ff, req_file_byte};
   assign seg_len               = wr_idx_ff + 16'd1;

   jeop_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_file_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   jeop_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .seg_len (seg_len),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .result  (walk)
   );

   always_comb begin
      phase_in     = phase_ff;
      remain_in    = remain_ff;
      len_hi_in    = len_hi_ff;
      marker_in    = marker_ff;
      wr_idx_in    = wr_idx_ff;
      found_in     = found_ff;
      sent_in      = sent_ff;
      walking_in   = walking_ff;
      last_pend_in = last_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      fin          = 1'b0;
      last_v       = 1'b0;
      start        = 1'b0;
      mem_we       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         last_v = req_last_byte;
         fin    = 1'b1;
         case (phase_ff)
            PH_SOI0: begin
               phase_in = (req_file_byte == jeop_pkg::MK_FILL) ? PH_SOI1 : PH_DONE;
            end
            PH_SOI1: begin
               phase_in = (req_file_byte == jeop_pkg::MK_SOI) ? PH_MARK_FF : PH_DONE;
            end
            PH_MARK_FF: begin
               phase_in = (req_file_byte == jeop_pkg::MK_FILL) ? PH_MARKER : PH_DONE;
            end
            PH_MARKER: begin
               if (req_file_byte == jeop_pkg::MK_FILL) begin
                  phase_in = PH_MARKER;
               end else if ((req_file_byte == jeop_pkg::MK_SOS) ||
                            (req_file_byte == jeop_pkg::MK_EOI)) begin
                  phase_in = PH_DONE;
               end else if ((req_file_byte == jeop_pkg::MK_TEM) ||
                            ((req_file_byte >= jeop_pkg::MK_RST0) &&
                             (req_file_byte <= jeop_pkg::MK_RST7))) begin
                  phase_in = PH_MARK_FF;
               end else begin
                  marker_in = req_file_byte;
                  phase_in  = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_hi_in = req_file_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (total < 16'd2) begin
                  phase_in = PH_DONE;
               end else begin
                  remain_in = total - 16'd2;
                  wr_idx_in = '0;
                  if (total == 16'd2) begin
                     phase_in = PH_MARK_FF;
                  end else begin
                     phase_in = (marker_ff == jeop_pkg::MK_APP1) ? PH_STORE : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  phase_in = PH_MARK_FF;
               end
            end
            PH_STORE: begin
               mem_we    = 1'b1;
               wr_idx_in = wr_idx_ff + 16'd1;
               remain_in = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  start        = 1'b1;
                  walking_in   = 1'b1;
                  last_pend_in = req_last_byte;
                  fin          = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (walking_ff && walk.done) begin
         walking_in = 1'b0;
         fin        = 1'b1;
         last_v     = last_pend_ff;
         if (walk.decided) begin
            found_in = walk.value;
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_MARK_FF;
         end
      end

      if (fin) begin
         if (!sent_ff && ((phase_in == PH_DONE) || last_v)) begin
            rsp_valid_in = 1'b1;
            rsp_val_in   = found_in;
            sent_in      = 1'b1;
         end
         if (last_v) begin
            phase_in  = PH_SOI0;
            remain_in = '0;
            len_hi_in = '0;
            marker_in = '0;
            wr_idx_in = '0;
            found_in  = jeop_pkg::ORIENT_DEFAULT;
            sent_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOI0;
         remain_ff    <= '0;
         len_hi_ff    <= '0;
         marker_ff    <= '0;
         wr_idx_ff    <= '0;
         found_ff     <= jeop_pkg::ORIENT_DEFAULT;
         sent_ff      <= 1'b0;
         walking_ff   <= 1'b0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         len_hi_ff    <= len_hi_in;
         marker_ff    <= marker_in;
         wr_idx_ff    <= wr_idx_in;
         found_ff     <= found_in;
         sent_ff      <= sent_in;
         walking_ff   <= walking_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_val_ff <= rsp_val_in;
   end

endmodule
